### rtl/glb_pkg.sv
package glb_pkg;

  typedef enum logic [1:0] {
    KIND_GLYPH   = 2'd0,
    KIND_SPACE   = 2'd1,
    KIND_NEWLINE = 2'd2,
    KIND_END     = 2'd3
  } char_kind_e;

  localparam int unsigned OUT_POS_BITS = 24;
  localparam int unsigned ROW_W_BITS   = 13;
  localparam int unsigned GLYPH_BITS   = 10;
  localparam int unsigned ACC_BITS     = 16;

  localparam logic [ROW_W_BITS-1:0] ROW_WIDTH_RESET = 13'd640;
  localparam logic [ACC_BITS-1:0]   WIDTH_MAX       = 16'hFFFF;

  typedef struct packed {
    logic [OUT_POS_BITS-1:0] row_begin;
    logic [OUT_POS_BITS-1:0] row_end;
    logic                    final_row;
  } row_t;

  // width accumulate, saturating at the top of the accumulator
  function automatic logic [ACC_BITS-1:0] sat_add(
    input logic [ACC_BITS-1:0]   a,
    input logic [GLYPH_BITS-1:0] b
  );
    logic [ACC_BITS:0] s;
    s = {1'b0, a} + (ACC_BITS + 1)'(b);
    return s[ACC_BITS] ? WIDTH_MAX : s[ACC_BITS-1:0];
  endfunction

endpackage

### rtl/glb_step.sv
module glb_step #(
  parameter int unsigned POSITION_BITS = 24
) (
  input  logic [1:0]                        kind_i,
  input  logic [glb_pkg::GLYPH_BITS-1:0]    gw_i,
  input  logic [glb_pkg::ROW_W_BITS-1:0]    row_width_i,
  input  logic [POSITION_BITS-1:0]          pos_i,
  input  logic [POSITION_BITS-1:0]          start_i,
  input  logic [POSITION_BITS-1:0]          brk_i,
  input  logic [glb_pkg::ACC_BITS-1:0]      rw_i,
  input  logic [glb_pkg::ACC_BITS-1:0]      wtb_i,
  output logic [POSITION_BITS-1:0]          pos_o,
  output logic [POSITION_BITS-1:0]          start_o,
  output logic [POSITION_BITS-1:0]          brk_o,
  output logic [glb_pkg::ACC_BITS-1:0]      rw_o,
  output logic [glb_pkg::ACC_BITS-1:0]      wtb_o,
  output logic                              emit_o,
  output glb_pkg::row_t                     row_o
);
  import glb_pkg::*;

  logic [POSITION_BITS-1:0] next_pos;
  logic [POSITION_BITS-1:0] brk_next;
  logic [ACC_BITS-1:0]      total;
  logic [ACC_BITS-1:0]      tail;
  logic                     overflow;

  assign next_pos = pos_i + POSITION_BITS'(1);
  assign brk_next = brk_i + POSITION_BITS'(1);
  assign total    = sat_add(rw_i, gw_i);
  assign overflow = total > ACC_BITS'(row_width_i);
  assign tail     = (rw_i >= wtb_i) ? (rw_i - wtb_i) : '0;

  always_comb begin
    pos_o   = next_pos;
    start_o = start_i;
    brk_o   = brk_i;
    rw_o    = rw_i;
    wtb_o   = wtb_i;
    emit_o  = 1'b0;
    row_o.row_begin = OUT_POS_BITS'(start_i);
    row_o.row_end   = OUT_POS_BITS'(pos_i);
    row_o.final_row = 1'b0;

    case (char_kind_e'(kind_i))
      KIND_END: begin
        emit_o          = 1'b1;
        row_o.final_row = 1'b1;
        pos_o   = '0;
        start_o = '0;
        brk_o   = '0;
        rw_o    = '0;
        wtb_o   = '0;
      end
      KIND_NEWLINE: begin
        emit_o  = 1'b1;
        start_o = next_pos;
        brk_o   = next_pos;
        rw_o    = '0;
        wtb_o   = '0;
      end
      KIND_SPACE: begin
        if (start_i == pos_i) begin
          // leading space, skipped
          start_o = next_pos;
          brk_o   = next_pos;
          rw_o    = '0;
          wtb_o   = '0;
        end else begin
          brk_o = pos_i;
          rw_o  = total;
          wtb_o = total;
        end
      end
      KIND_GLYPH: begin
        if (overflow) begin
          emit_o = 1'b1;
          wtb_o  = '0;
          if (start_i == brk_i) begin
            // no space in row: cut after this glyph
            row_o.row_end = OUT_POS_BITS'(next_pos);
            start_o = next_pos;
            brk_o   = next_pos;
            rw_o    = '0;
          end else begin
            row_o.row_end = OUT_POS_BITS'(brk_i);
            start_o = brk_next;
            brk_o   = brk_next;
            rw_o    = sat_add(tail, gw_i);
          end
        end else begin
          rw_o = total;
        end
      end
      default: begin
        pos_o = next_pos;
      end
    endcase
  end

endmodule

### rtl/glb_out_reg.sv
module glb_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  glb_pkg::row_t row_i,
  output logic          free_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output glb_pkg::row_t row_o
);
  import glb_pkg::*;

  logic valid_q;
  row_t row_q;

  assign free_o      = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign row_o       = row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && push_i) begin
      row_q <= row_i;
    end
  end

endmodule

### rtl/greedy_line_breaker.sv
// a request passes the input register, the combinational row step, the result register
// throughput: one character per cycle while in_stall_o is low
// an output stall holds a character in the input register only if it closes a row
// reset: asynchronous active low, clears position, row start, break point, both
// width accumulators and both valid flags, and loads row width with 640
module greedy_line_breaker #(
  parameter int unsigned POSITION_BITS = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration, written while idle
  input  logic                              cfg_we_i,
  input  logic [glb_pkg::ROW_W_BITS-1:0]    cfg_wdata_i,
  // character requests
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        char_kind_i,
  input  logic [glb_pkg::GLYPH_BITS-1:0]    glyph_width_i,
  // row requests
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [glb_pkg::OUT_POS_BITS-1:0]  row_begin_o,
  output logic [glb_pkg::OUT_POS_BITS-1:0]  row_end_o,
  output logic                              final_row_o
);
  import glb_pkg::*;

  // configured row width
  logic [ROW_W_BITS-1:0] row_width_q;

  // input register
  logic                  in_valid_q;
  logic [1:0]            kind_q;
  logic [GLYPH_BITS-1:0] gw_q;

  // row state
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [POSITION_BITS-1:0] start_q, start_d;
  logic [POSITION_BITS-1:0] brk_q, brk_d;
  logic [ACC_BITS-1:0]      rw_q, rw_d;
  logic [ACC_BITS-1:0]      wtb_q, wtb_d;

  logic emit;
  logic out_free;
  logic step_go;
  logic in_take;
  row_t row_step;
  row_t row_out;

  // a character retires unless it closes a row and the output slot is held
  assign step_go    = in_valid_q && (!emit || out_free);
  assign in_stall_o = in_valid_q && !step_go;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= ROW_WIDTH_RESET;
    end else if (cfg_we_i) begin
      row_width_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      kind_q <= char_kind_i;
      gw_q   <= glyph_width_i;
    end
  end

  // combinational row step
  glb_step #(
    .POSITION_BITS (POSITION_BITS)
  ) u_step (
    .kind_i      (kind_q),
    .gw_i        (gw_q),
    .row_width_i (row_width_q),
    .pos_i       (pos_q),
    .start_i     (start_q),
    .brk_i       (brk_q),
    .rw_i        (rw_q),
    .wtb_i       (wtb_q),
    .pos_o       (pos_d),
    .start_o     (start_d),
    .brk_o       (brk_d),
    .rw_o        (rw_d),
    .wtb_o       (wtb_d),
    .emit_o      (emit),
    .row_o       (row_step)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      start_q <= '0;
      brk_q   <= '0;
      rw_q    <= '0;
      wtb_q   <= '0;
    end else if (step_go) begin
      pos_q   <= pos_d;
      start_q <= start_d;
      brk_q   <= brk_d;
      rw_q    <= rw_d;
      wtb_q   <= wtb_d;
    end
  end

  // result register, decouples the output stall from the step
  glb_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step_go && emit),
    .row_i       (row_step),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .row_o       (row_out)
  );

  assign row_begin_o = row_out.row_begin;
  assign row_end_o   = row_out.row_end;
  assign final_row_o = row_out.final_row;

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import glb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  // allowance from request to row on the outputs, plus margin
  localparam int unsigned SETTLE_CYCLES = 4;

  typedef struct packed {
    char_kind_e      kind;
    logic [GLYPH_BITS-1:0] gw;
  } char_req_t;

  // dut ports
  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    cfg_we_i      = 1'b0;
  logic [ROW_W_BITS-1:0]   cfg_wdata_i   = '0;
  logic                    in_valid_i    = 1'b0;
  logic                    in_stall_o;
  logic [1:0]              char_kind_i   = KIND_GLYPH;
  logic [GLYPH_BITS-1:0]   glyph_width_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i   = 1'b0;
  logic [OUT_POS_BITS-1:0] row_begin_o;
  logic [OUT_POS_BITS-1:0] row_end_o;
  logic                    final_row_o;

  // wrap state of the predictor, mirrors what the block keeps per text
  logic [ROW_W_BITS-1:0]   wrap_row_width = ROW_WIDTH_RESET;
  logic [OUT_POS_BITS-1:0] wrap_pos       = '0;
  logic [OUT_POS_BITS-1:0] wrap_row_start = '0;
  logic [OUT_POS_BITS-1:0] wrap_break     = '0;
  logic [ACC_BITS-1:0]     wrap_run_w     = '0;
  logic [ACC_BITS-1:0]     wrap_break_w   = '0;

  // rows still owed by the block, oldest first
  row_t rows_pending[$];
  row_t row_want;

  // traffic shaping, owned by the test tasks
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int          hold_left     = 0;

  // bookkeeping
  int unsigned cycle_cnt     = 0;
  int unsigned err_cnt       = 0;
  int unsigned chars_sent    = 0;
  int unsigned rows_seen     = 0;
  int unsigned finals_seen   = 0;
  int unsigned width_changes = 0;

  greedy_line_breaker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .char_kind_i   (char_kind_i),
    .glyph_width_i (glyph_width_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .row_begin_o   (row_begin_o),
    .row_end_o     (row_end_o),
    .final_row_o   (final_row_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // watchdog, a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d rows still owed", cycle_cnt, rows_pending.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver stall: a long hold-off when requested, random stalls otherwise
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // saturating width accumulate
  function automatic logic [ACC_BITS-1:0] width_add(
    input logic [ACC_BITS-1:0]   acc,
    input logic [GLYPH_BITS-1:0] w
  );
    logic [ACC_BITS:0] sum;
    sum = {1'b0, acc} + {{(ACC_BITS + 1 - GLYPH_BITS){1'b0}}, w};
    if (sum > {1'b0, WIDTH_MAX}) return WIDTH_MAX;
    return sum[ACC_BITS-1:0];
  endfunction

  // append a row to the tail of the owed list
  function automatic void owe_row(input row_t r);
    rows_pending = {rows_pending, r};
  endfunction

  // advance the wrap state by one character, queue the row it closes if any
  task automatic wrap_char(input char_kind_e kind, input logic [GLYPH_BITS-1:0] gw);
    logic [OUT_POS_BITS-1:0] nxt;
    logic [ACC_BITS-1:0]     total;
    logic [ACC_BITS-1:0]     tail;
    nxt = wrap_pos + OUT_POS_BITS'(1);
    case (kind)
      KIND_END: begin
        // close the open row and start a fresh text
        owe_row('{row_begin: wrap_row_start, row_end: wrap_pos, final_row: 1'b1});
        wrap_pos       = '0;
        wrap_row_start = '0;
        wrap_break     = '0;
        wrap_run_w     = '0;
        wrap_break_w   = '0;
        return;
      end
      KIND_NEWLINE: begin
        // newline width is ignored, next row opens after it
        owe_row('{row_begin: wrap_row_start, row_end: wrap_pos, final_row: 1'b0});
        wrap_row_start = nxt;
        wrap_break     = nxt;
        wrap_run_w     = '0;
        wrap_break_w   = '0;
      end
      KIND_SPACE: begin
        if (wrap_row_start == wrap_pos) begin
          // leading space, skipped without width
          wrap_row_start = nxt;
          wrap_break     = nxt;
          wrap_run_w     = '0;
          wrap_break_w   = '0;
        end else begin
          // space becomes the break point, no width check
          wrap_break   = wrap_pos;
          wrap_run_w   = width_add(wrap_run_w, gw);
          wrap_break_w = wrap_run_w;
        end
      end
      default: begin
        total = width_add(wrap_run_w, gw);
        if (total > wrap_row_width) begin
          if (wrap_row_start == wrap_break) begin
            // no space in the row: break right after this glyph
            owe_row('{row_begin: wrap_row_start, row_end: nxt, final_row: 1'b0});
            wrap_row_start = nxt;
            wrap_break     = nxt;
            wrap_run_w     = '0;
          end else begin
            // break at the last space, the word tail moves down with this glyph
            tail = (wrap_run_w >= wrap_break_w) ? wrap_run_w - wrap_break_w : '0;
            owe_row('{row_begin: wrap_row_start, row_end: wrap_break, final_row: 1'b0});
            wrap_row_start = wrap_break + OUT_POS_BITS'(1);
            wrap_break     = wrap_row_start;
            wrap_run_w     = width_add(tail, gw);
          end
          wrap_break_w = '0;
        end else begin
          wrap_run_w = total;
        end
      end
    endcase
    wrap_pos = nxt;
  endtask

  task automatic flag_mismatch(
    input string                   what,
    input logic [OUT_POS_BITS-1:0] want_v,
    input logic [OUT_POS_BITS-1:0] got_v
  );
    err_cnt++;
    if (err_cnt <= 10)
      $display("mismatch in %s at cycle %0d: expected %0h, got %0h", what, cycle_cnt, want_v,
               got_v);
  endtask

  // row checker, every accepted row against the oldest one owed
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      rows_seen++;
      if (final_row_o) finals_seen++;
      if (rows_pending.size() == 0) begin
        flag_mismatch("row with nothing owed, row_begin", '0, row_begin_o);
      end else begin
        row_want = rows_pending.pop_front();
        if (row_begin_o !== row_want.row_begin)
          flag_mismatch("row_begin", row_want.row_begin, row_begin_o);
        if (row_end_o !== row_want.row_end)
          flag_mismatch("row_end", row_want.row_end, row_end_o);
        if (final_row_o !== row_want.final_row)
          flag_mismatch("final_row", {23'd0, row_want.final_row}, {23'd0, final_row_o});
      end
    end
  end

  // offer one character request, hold it until the block takes it
  task automatic send_char(input char_kind_e kind, input logic [GLYPH_BITS-1:0] gw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    char_kind_i   <= kind;
    glyph_width_i <= gw;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    wrap_char(kind, gw);
    chars_sent++;
  endtask

  // all rows in, then let a character that closes nothing finish too
  task automatic wait_drained();
    while (rows_pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // row width only changes with the block idle
  task automatic set_row_width(input logic [ROW_W_BITS-1:0] w);
    in_valid_i <= 1'b0;
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    wrap_row_width  = w;
    width_changes++;
  endtask

  function automatic logic [GLYPH_BITS-1:0] pick_width();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65) return GLYPH_BITS'($urandom_range(1, 70));
    if (r < 85) return GLYPH_BITS'($urandom_range(0, 1023));
    if (r < 92) return '0;
    return '1;
  endfunction

  // mostly text-like: words, spaces, some newlines and ends, a little noise
  function automatic char_req_t random_char();
    int unsigned r;
    char_req_t   c;
    r = $urandom_range(99);
    if (r < 58)      c.kind = KIND_GLYPH;
    else if (r < 82) c.kind = KIND_SPACE;
    else if (r < 92) c.kind = KIND_NEWLINE;
    else if (r < 96) c.kind = KIND_END;
    else             c.kind = char_kind_e'($urandom_range(3));
    c.gw = (r >= 96) ? GLYPH_BITS'($urandom_range(1023)) : pick_width();
    return c;
  endfunction

  // reset row width of 640, every kind, both break styles, leading spaces
  task automatic test_directed_wrap();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_char(KIND_GLYPH,   10'd1023);  // lone glyph past the width, mid-word break
    send_char(KIND_SPACE,   10'd5);     // leading spaces skipped
    send_char(KIND_SPACE,   10'd7);
    send_char(KIND_GLYPH,   10'd300);
    send_char(KIND_GLYPH,   10'd300);
    send_char(KIND_SPACE,   10'd10);
    send_char(KIND_GLYPH,   10'd20);
    send_char(KIND_GLYPH,   10'd20);    // overflow, break at the space
    send_char(KIND_NEWLINE, 10'd1023);  // newline width ignored
    send_char(KIND_GLYPH,   10'd0);
    send_char(KIND_SPACE,   10'd0);
    send_char(KIND_GLYPH,   10'd640);   // exactly fills the row
    send_char(KIND_GLYPH,   10'd1);     // one past, break at the space
    send_char(KIND_NEWLINE, 10'd0);
    send_char(KIND_NEWLINE, 10'd0);     // empty row
    send_char(KIND_END,     10'd1023);  // final row, state back to reset
    send_char(KIND_END,     10'd0);     // empty final row at position zero
    send_char(KIND_GLYPH,   10'd5);
    send_char(KIND_END,     10'd5);
  endtask

  // a zero row width makes every glyph with width overflow
  task automatic test_zero_row_width();
    set_row_width('0);
    send_char(KIND_GLYPH,   10'd0);
    send_char(KIND_GLYPH,   10'd5);
    send_char(KIND_SPACE,   10'd3);
    send_char(KIND_GLYPH,   10'd5);
    send_char(KIND_GLYPH,   10'd0);
    send_char(KIND_NEWLINE, 10'd1);
    send_char(KIND_END,     10'd0);
  endtask

  // spaces pile width past the accumulator top, then a glyph breaks at the last one
  task automatic test_width_saturation();
    set_row_width('1);
    send_char(KIND_GLYPH, 10'd10);
    repeat (68) send_char(KIND_SPACE, 10'd1023);
    send_char(KIND_GLYPH, 10'd1);
    send_char(KIND_GLYPH, 10'd1023);
    send_char(KIND_END,   10'd0);
  endtask

  // receiver holds off long enough that the block backs up into its input
  task automatic test_backpressure();
    set_row_width(13'd200);
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = 300;
    repeat (60) begin
      if ($urandom_range(1)) send_char(KIND_NEWLINE, pick_width());
      else                   send_char(KIND_GLYPH, 10'd150);
    end
    send_char(KIND_END, 10'd0);
  endtask

  task automatic test_random_text(
    input int unsigned           n_chars,
    input int unsigned           idle_pct,
    input int unsigned           rx_stall_pct,
    input logic [ROW_W_BITS-1:0] w
  );
    char_req_t c;
    set_row_width(w);
    send_idle_pct = idle_pct;
    stall_pct     = rx_stall_pct;
    repeat (n_chars) begin
      c = random_char();
      send_char(c.kind, c.gw);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_directed_wrap();
    test_zero_row_width();
    test_width_saturation();
    test_backpressure();
    // idling phases: none, sender, receiver, both
    test_random_text(175, 0, 0, 13'd200);
    test_random_text(175, 76, 0, '1);
    test_random_text(175, 0, 76, 13'd1);
    test_random_text(175, 24, 24, ROW_W_BITS'($urandom_range(40, 2000)));

    in_valid_i    <= 1'b0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    wait_drained();

    $display("sent %0d characters over %0d row width settings, checked %0d rows (%0d final)",
             chars_sent, width_changes, rows_seen, finals_seen);
    $display("mismatches counted: %0d", err_cnt);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
